### src/assert_macros.svh
// Shared assertion macros for the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/bcpc_pkg.sv
package bcpc_pkg;

  localparam int unsigned POWER_LIMIT = 1000;
  localparam int unsigned DIV_W       = 20;
  localparam logic [DIV_W-1:0] US_PER_SEC = 20'd1000000;

  // Register indexes
  localparam logic [2:0] REG_HOME_STATE   = 3'd0;
  localparam logic [2:0] REG_TARGET_SPEED = 3'd1;
  localparam logic [2:0] REG_TARGET_POS   = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN   = 3'd3;
  localparam logic [2:0] REG_POS_GAIN     = 3'd4;
  localparam logic [2:0] REG_DERIV_GAIN   = 3'd5;

  // Request kinds
  localparam logic REQ_HALL = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [5:0] DRIVE_TAB [8] = '{6'h12, 6'h18, 6'h09, 6'h21,
                                           6'h24, 6'h06, 6'h00, 6'h00};
  localparam logic [2:0] ROTOR_TAB [8] = '{3'd7, 3'd5, 3'd3, 3'd4,
                                           3'd1, 3'd0, 3'd2, 3'd7};

  typedef struct packed {
    logic        req_type;
    logic [2:0]  hall_code;
    logic [19:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         phase_pattern;
    logic [9:0]         pwm_width;
    logic signed [31:0] position;
    logic signed [31:0] position_error;
    logic signed [31:0] measured_speed;
  } out_word_t;

endpackage

### src/bcpc_div.sv
// Restoring divider: one quotient bit per cycle, fixed dividend of one second in us.
module bcpc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bcpc_pkg::DIV_W-1:0]   divisor,
  output logic                         done,
  output logic [bcpc_pkg::DIV_W-1:0]   quotient
);

  logic [bcpc_pkg::DIV_W:0]   rem;
  logic [bcpc_pkg::DIV_W-1:0] num;
  logic [bcpc_pkg::DIV_W-1:0] dvs;
  logic [4:0]                 count;
  logic                       busy;
  logic [bcpc_pkg::DIV_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem[bcpc_pkg::DIV_W-1:0], num[bcpc_pkg::DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'(bcpc_pkg::DIV_W - 1);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      num      <= bcpc_pkg::US_PER_SEC;
      dvs      <= (divisor == '0) ? bcpc_pkg::DIV_W'(1) : divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= fits ? rem_sh - {1'b0, dvs} : rem_sh;
      num      <= {num[bcpc_pkg::DIV_W-2:0], 1'b0};
      quotient <= {quotient[bcpc_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

### src/bcpc_mul.sv
// Shared multiplier, low 32 bits of the product, registered.
module bcpc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] product
);

  logic [63:0] full;
  assign full = a * b;

  always_ff @(posedge clk) begin
    product <= full[31:0];
  end

endmodule

### src/bldc_commutation_position_control.sv
// Six-step hall commutation with speed and position regulation. A hall word
// passes through the hall step and the done state into the output register.
// A control tick waits for the 20-iteration bit-serial divider that forms
// 1000000/elapsed_us, then takes four passes through one shared 32x32
// multiplier, a sum and a decision step, and then the hall step when a zero
// measured speed also recommutates. One word is in work at a time; in_ready is
// high whenever the sequencer is idle, even while a finished result waits in
// the output register, and a result that cannot enter a full output register
// stalls the sequencer until it can.
// Configuration writes are taken in any cycle and must occur while idle.
module bldc_commutation_position_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bcpc_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bcpc_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_HALL = 10'b0000000010,
    S_DIVW = 10'b0000000100,
    S_MACT = 10'b0000001000,
    S_MSPD = 10'b0000010000,
    S_MPOS = 10'b0000100000,
    S_MDER = 10'b0001000000,
    S_SUM  = 10'b0010000000,
    S_DEC  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;

  // Configuration
  logic [2:0]  home_state;
  logic [15:0] target_speed;
  logic [31:0] target_position;
  logic [7:0]  speed_gain, position_gain, derivative_gain;

  // Controller state
  logic [2:0]  previous_rotor;
  logic [31:0] rotor_position, tick_position, previous_error, last_speed;
  logic        reverse_lead;
  logic [10:0] drive_power;
  logic [5:0]  current_pattern;

  // Work registers
  logic [2:0]  code;
  logic [31:0] err, ys_raw, p1, yr, ys;

  logic        div_start, div_done;
  logic [19:0] quotient;
  logic [31:0] mul_a, mul_b, product;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign div_start = in_valid && in_ready && (in_data.req_type == bcpc_pkg::REQ_TICK);

  bcpc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (in_data.elapsed_us),
    .done    (div_done),
    .quotient(quotient)
  );

  bcpc_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .product(product)
  );

  function automatic logic [31:0] mag(input logic [31:0] v);
    mag = v[31] ? 32'd0 - v : v;
  endfunction

  // Hall step
  logic [2:0]  rotor;
  logic [4:0]  comm;
  logic [4:0]  comm_red;
  logic [2:0]  comm_idx;
  logic [3:0]  delta;
  logic [31:0] pos_step;

  always_comb begin
    rotor = bcpc_pkg::ROTOR_TAB[code];
    comm  = {2'b0, rotor} + 5'd6 + (reverse_lead ? 5'd30 : 5'd2) - {2'b0, home_state};
    if (comm >= 5'd12)     comm_red = comm - 5'd12;
    else if (comm >= 5'd6) comm_red = comm - 5'd6;
    else                   comm_red = comm;
    // negative remainder keeps its low bits
    comm_idx = comm[4] ? comm[2:0] : comm_red[2:0];
    delta    = {1'b0, rotor} - {1'b0, previous_rotor};
    if (delta == 4'sd5)       pos_step = 32'hFFFF_FFFF;
    else if (delta == 4'b1011) pos_step = 32'd1;
    else                      pos_step = {{28{delta[3]}}, delta};
  end

  // Select multiplier operands
  logic [31:0] act_err;
  always_comb begin
    act_err = (target_position != 32'd0) ? target_position - rotor_position : 32'd1;
    case (state)
      S_MACT: begin
        mul_a = rotor_position - tick_position;
        mul_b = {12'b0, quotient};
      end
      S_MSPD: begin
        mul_a = {16'b0, target_speed} - mag(product);
        mul_b = {24'b0, speed_gain};
      end
      S_MPOS: begin
        mul_a = err;
        mul_b = {24'b0, position_gain};
      end
      S_MDER: begin
        mul_a = err - previous_error;
        mul_b = {24'b0, derivative_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = (in_data.req_type == bcpc_pkg::REQ_TICK) ? S_DIVW : S_HALL;
      S_HALL: state_next = S_DONE;
      S_DIVW: if (div_done) state_next = S_MACT;
      S_MACT: state_next = S_MSPD;
      S_MSPD: state_next = S_MPOS;
      S_MPOS: state_next = S_MDER;
      S_MDER: state_next = S_SUM;
      S_SUM:  state_next = S_DEC;
      S_DEC:  state_next = (last_speed == 32'd0) ? S_HALL : S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Hold configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      home_state      <= 3'd0;
      target_speed    <= 16'd240;
      target_position <= 32'd1;
      speed_gain      <= 8'd20;
      position_gain   <= 8'd15;
      derivative_gain <= 8'd47;
    end else if (cfg_valid) begin
      case (cfg_index)
        bcpc_pkg::REG_HOME_STATE:   home_state      <= cfg_data[2:0];
        bcpc_pkg::REG_TARGET_SPEED: target_speed    <= cfg_data[15:0];
        bcpc_pkg::REG_TARGET_POS:   target_position <= cfg_data;
        bcpc_pkg::REG_SPEED_GAIN:   speed_gain      <= cfg_data[7:0];
        bcpc_pkg::REG_POS_GAIN:     position_gain   <= cfg_data[7:0];
        bcpc_pkg::REG_DERIV_GAIN:   derivative_gain <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Work registers, no reset needed
  logic [31:0] ys_sel, y, y_mag;
  always_comb begin
    ys_sel = (target_speed == 16'd0) ? 32'(bcpc_pkg::POWER_LIMIT) : ys_raw;
    if (err[31]) ys_sel = 32'd0 - ys_sel;
    if (target_position == 32'd0)   y = ys;
    else if (mag(yr) < mag(ys))     y = yr;
    else                            y = ys;
    y_mag = mag(y);
    if (y_mag > 32'(bcpc_pkg::POWER_LIMIT)) y_mag = 32'(bcpc_pkg::POWER_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code    <= in_data.hall_code;
    end
    if (state == S_MSPD) err    <= act_err;
    if (state == S_MPOS) ys_raw <= product;
    if (state == S_MDER) p1     <= product;
    if (state == S_SUM) begin
      yr <= p1 + product;
      ys <= ys_sel;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_rotor  <= 3'd0;
      rotor_position  <= '0;
      tick_position   <= '0;
      previous_error  <= '0;
      last_speed      <= '0;
      reverse_lead    <= 1'b0;
      drive_power     <= 11'(bcpc_pkg::POWER_LIMIT);
      current_pattern <= 6'h12;
    end else begin
      case (state)
        S_HALL: begin
          current_pattern <= bcpc_pkg::DRIVE_TAB[comm_idx];
          rotor_position  <= rotor_position + pos_step;
          previous_rotor  <= rotor;
        end
        S_MSPD: begin
          last_speed    <= product;
          tick_position <= rotor_position;
        end
        S_DEC: begin
          reverse_lead   <= y[31];
          drive_power    <= y_mag[10:0];
          previous_error <= err;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.phase_pattern  <= current_pattern;
      out_data.pwm_width      <= drive_power[9:0];
      out_data.position       <= rotor_position;
      out_data.position_error <= previous_error;
      out_data.measured_speed <= last_speed;
    end
  end

endmodule

### src/bcpc_checker.sv
`include "assert_macros.svh"

module bcpc_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bcpc_pkg::out_word_t out_data
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_NEXT(a_one_in_work, clk, rst, in_valid && in_ready, !in_ready)
  `ASSERT_SAME(a_pwm_limit, clk, rst, out_valid, out_data.pwm_width <= 10'(bcpc_pkg::POWER_LIMIT))

endmodule

bind bldc_commutation_position_control bcpc_checker u_bcpc_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
